// File: src/boundary_tag_next_fit_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// boundary tag next-fit allocator: assertion macros
// clocked assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_NEXT_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define BOUNDARY_TAG_NEXT_FIT_ALLOCATOR_UNIT_MACROS_SVH

// checked on every rising edge of clk, off while rst_n is low
`define BTNF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge of clk, also during reset
`define BTNF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/btnf_pkg.sv
// ----------------------------------------------------------------------------
// btnf_pkg
// shared types, constants and functions of the next-fit allocator
// ----------------------------------------------------------------------------
package btnf_pkg;

  // default parameter values
  localparam int unsigned DEF_HEAP_BYTES = 65536;
  localparam int unsigned DEF_GROW_BYTES = 4096;

  // field and datapath widths
  localparam int KIND_W = 1;
  localparam int REQ_W  = 17;
  localparam int BADDR_W = 16;
  localparam int PADDR_W = 16;
  localparam int WORD_W = 32;

  // kind codes
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  // heap layout after reset
  localparam logic [WORD_W-1:0] HEAP_START  = 32'd8;
  localparam logic [WORD_W-1:0] INIT_BREAK  = 32'd4120;
  localparam logic [WORD_W-1:0] INIT_ROVER  = 32'd16;
  localparam logic [WORD_W-1:0] MIN_BLOCK   = 32'd16;

  localparam logic [WORD_W-1:0] PRO_HDR_IDX  = 32'd1;
  localparam logic [WORD_W-1:0] PRO_FTR_IDX  = 32'd2;
  localparam logic [WORD_W-1:0] FREE_HDR_IDX = 32'd3;
  localparam logic [WORD_W-1:0] STALE0_IDX   = 32'd4;
  localparam logic [WORD_W-1:0] STALE1_IDX   = 32'd5;
  localparam logic [WORD_W-1:0] FREE_FTR_IDX = 32'd1028;
  localparam logic [WORD_W-1:0] EPI_IDX      = 32'd1029;

  localparam logic [WORD_W-1:0] PRO_TAG    = 32'd9;
  localparam logic [WORD_W-1:0] FREE_TAG   = 32'd4104;
  localparam logic [WORD_W-1:0] STALE0_TAG = 32'd8;
  localparam logic [WORD_W-1:0] STALE1_TAG = 32'd4096;
  localparam logic [WORD_W-1:0] EPI_TAG    = 32'd1;

  // datapath commands issued by the controller
  typedef enum logic [5:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_S_RD,
    OP_S_EVAL,
    OP_S2_INIT,
    OP_G_INIT,
    OP_G_W1,
    OP_G_W2,
    OP_G_W3,
    OP_M_RD0,
    OP_M_RD1,
    OP_M_RD2,
    OP_M_EVAL,
    OP_M_RDP,
    OP_M_ADDP,
    OP_M_WA,
    OP_M_WB,
    OP_M_FIN,
    OP_P_RD,
    OP_P_EVAL,
    OP_P_W1,
    OP_P_W2,
    OP_P_W3,
    OP_P_W4,
    OP_P_N1,
    OP_P_N2,
    OP_F_RD,
    OP_F_EVAL,
    OP_F_W1,
    OP_F_W2,
    OP_PUSH
  } btnf_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic sweep_last;
    logic kind_free;
    logic req_zero;
    logic s1_go;
    logic s2_go;
    logic sz_zero;
    logic fits;
    logic nxt_le;
    logic grow_ok;
    logic prev_free;
    logic next_free;
    logic split;
    logic free_pre_ok;
    logic foot_eq;
  } btnf_status_t;

  // tag word value after reset, by word index
  function automatic logic [WORD_W-1:0] init_word(input logic [WORD_W-1:0] idx);
    logic [WORD_W-1:0] v;
    v = '0;
    if (idx == PRO_HDR_IDX || idx == PRO_FTR_IDX) v = PRO_TAG;
    else if (idx == FREE_HDR_IDX || idx == FREE_FTR_IDX) v = FREE_TAG;
    else if (idx == STALE0_IDX) v = STALE0_TAG;
    else if (idx == STALE1_IDX) v = STALE1_TAG;
    else if (idx == EPI_IDX) v = EPI_TAG;
    return v;
  endfunction

endpackage

// File: src/btnf_in_if.sv
// ----------------------------------------------------------------------------
// btnf_in_if
// request channel: valid/ready with allocate or free payload
// ----------------------------------------------------------------------------
interface btnf_in_if import btnf_pkg::*;;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [REQ_W-1:0]   request_bytes;
  logic [BADDR_W-1:0] block_address;

  modport source (output valid, kind, request_bytes, block_address, input ready);
  modport sink (input valid, kind, request_bytes, block_address, output ready);
endinterface

// File: src/btnf_out_if.sv
// ----------------------------------------------------------------------------
// btnf_out_if
// result channel: valid/ready with payload address and success flag
// ----------------------------------------------------------------------------
interface btnf_out_if import btnf_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PADDR_W-1:0] payload_address;
  logic               success;

  modport source (output valid, payload_address, success, input ready);
  modport sink (input valid, payload_address, success, output ready);
endinterface

// File: src/btnf_ram.sv
// ----------------------------------------------------------------------------
// btnf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module btnf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: src/btnf_ctrl.sv
// ----------------------------------------------------------------------------
// btnf_ctrl
// sequencer for clearing pass, next-fit search, growth, merge, place, free
// ----------------------------------------------------------------------------
`include "boundary_tag_next_fit_allocator_unit_macros.svh"

module btnf_ctrl import btnf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  btnf_status_t st,
  output btnf_op_t     op
);
  typedef enum logic [35:0] {
    ST_CLEAR    = 36'd1 << 0,
    ST_IDLE     = 36'd1 << 1,
    ST_DISPATCH = 36'd1 << 2,
    ST_S1_CHK   = 36'd1 << 3,
    ST_S1_EVAL  = 36'd1 << 4,
    ST_S2_INIT  = 36'd1 << 5,
    ST_S2_CHK   = 36'd1 << 6,
    ST_S2_EVAL  = 36'd1 << 7,
    ST_G_INIT   = 36'd1 << 8,
    ST_G_CHK    = 36'd1 << 9,
    ST_G_W1     = 36'd1 << 10,
    ST_G_W2     = 36'd1 << 11,
    ST_G_W3     = 36'd1 << 12,
    ST_M_RD0    = 36'd1 << 13,
    ST_M_RD1    = 36'd1 << 14,
    ST_M_RD2    = 36'd1 << 15,
    ST_M_EVAL   = 36'd1 << 16,
    ST_M_RDP    = 36'd1 << 17,
    ST_M_ADDP   = 36'd1 << 18,
    ST_M_WA     = 36'd1 << 19,
    ST_M_WB     = 36'd1 << 20,
    ST_M_FIN    = 36'd1 << 21,
    ST_P_RD     = 36'd1 << 22,
    ST_P_EVAL   = 36'd1 << 23,
    ST_P_W1     = 36'd1 << 24,
    ST_P_W2     = 36'd1 << 25,
    ST_P_W3     = 36'd1 << 26,
    ST_P_W4     = 36'd1 << 27,
    ST_P_N1     = 36'd1 << 28,
    ST_P_N2     = 36'd1 << 29,
    ST_F_RD     = 36'd1 << 30,
    ST_F_EVAL   = 36'd1 << 31,
    ST_F_CMP    = 36'd1 << 32,
    ST_F_W1     = 36'd1 << 33,
    ST_F_W2     = 36'd1 << 34,
    ST_PUSH     = 36'd1 << 35
  } btnf_state_t;

  btnf_state_t state_r, state_nxt;
  logic        from_free_r, from_free_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;
  btnf_state_t merge_ret;

  assign out_free  = !out_valid_r || out_ready;
  assign merge_ret = from_free_r ? ST_PUSH : ST_P_RD;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    from_free_nxt = from_free_r;
    op            = OP_NONE;
    case (state_r)
      ST_CLEAR: begin
        op = OP_CLEAR;
        if (st.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        from_free_nxt = st.kind_free;
        if (st.kind_free) state_nxt = ST_F_RD;
        else if (st.req_zero) state_nxt = ST_PUSH;
        else state_nxt = ST_S1_CHK;
      end
      ST_S1_CHK: begin
        if (st.s1_go) begin
          op        = OP_S_RD;
          state_nxt = ST_S1_EVAL;
        end else begin
          state_nxt = ST_S2_INIT;
        end
      end
      ST_S1_EVAL: begin
        op = OP_S_EVAL;
        if (st.sz_zero) state_nxt = ST_S2_INIT;
        else if (st.fits) state_nxt = ST_P_RD;
        else if (st.nxt_le) state_nxt = ST_S2_INIT;
        else state_nxt = ST_S1_CHK;
      end
      ST_S2_INIT: begin
        op        = OP_S2_INIT;
        state_nxt = ST_S2_CHK;
      end
      ST_S2_CHK: begin
        if (st.s2_go) begin
          op        = OP_S_RD;
          state_nxt = ST_S2_EVAL;
        end else begin
          state_nxt = ST_G_INIT;
        end
      end
      ST_S2_EVAL: begin
        op = OP_S_EVAL;
        if (st.fits) state_nxt = ST_P_RD;
        else if (st.nxt_le) state_nxt = ST_G_INIT;
        else state_nxt = ST_S2_CHK;
      end
      ST_G_INIT: begin
        op        = OP_G_INIT;
        state_nxt = ST_G_CHK;
      end
      ST_G_CHK: begin
        state_nxt = st.grow_ok ? ST_G_W1 : ST_PUSH;
      end
      ST_G_W1: begin
        op        = OP_G_W1;
        state_nxt = ST_G_W2;
      end
      ST_G_W2: begin
        op        = OP_G_W2;
        state_nxt = ST_G_W3;
      end
      ST_G_W3: begin
        op        = OP_G_W3;
        state_nxt = ST_M_RD0;
      end
      ST_M_RD0: begin
        op        = OP_M_RD0;
        state_nxt = ST_M_RD1;
      end
      ST_M_RD1: begin
        op        = OP_M_RD1;
        state_nxt = ST_M_RD2;
      end
      ST_M_RD2: begin
        op        = OP_M_RD2;
        state_nxt = ST_M_EVAL;
      end
      ST_M_EVAL: begin
        op = OP_M_EVAL;
        if (!st.prev_free && !st.next_free) state_nxt = merge_ret;
        else if (st.prev_free) state_nxt = ST_M_RDP;
        else state_nxt = ST_M_WA;
      end
      ST_M_RDP: begin
        op        = OP_M_RDP;
        state_nxt = ST_M_ADDP;
      end
      ST_M_ADDP: begin
        op        = OP_M_ADDP;
        state_nxt = ST_M_WA;
      end
      ST_M_WA: begin
        op        = OP_M_WA;
        state_nxt = ST_M_WB;
      end
      ST_M_WB: begin
        op        = OP_M_WB;
        state_nxt = ST_M_FIN;
      end
      ST_M_FIN: begin
        op        = OP_M_FIN;
        state_nxt = merge_ret;
      end
      ST_P_RD: begin
        op        = OP_P_RD;
        state_nxt = ST_P_EVAL;
      end
      ST_P_EVAL: begin
        op        = OP_P_EVAL;
        state_nxt = st.split ? ST_P_W1 : ST_P_N1;
      end
      ST_P_W1: begin
        op        = OP_P_W1;
        state_nxt = ST_P_W2;
      end
      ST_P_W2: begin
        op        = OP_P_W2;
        state_nxt = ST_P_W3;
      end
      ST_P_W3: begin
        op        = OP_P_W3;
        state_nxt = ST_P_W4;
      end
      ST_P_W4: begin
        op        = OP_P_W4;
        state_nxt = ST_PUSH;
      end
      ST_P_N1: begin
        op        = OP_P_N1;
        state_nxt = ST_P_N2;
      end
      ST_P_N2: begin
        op        = OP_P_N2;
        state_nxt = ST_PUSH;
      end
      ST_F_RD: begin
        op        = OP_F_RD;
        state_nxt = ST_F_EVAL;
      end
      ST_F_EVAL: begin
        op        = OP_F_EVAL;
        state_nxt = st.free_pre_ok ? ST_F_CMP : ST_PUSH;
      end
      ST_F_CMP: begin
        state_nxt = st.foot_eq ? ST_F_W1 : ST_PUSH;
      end
      ST_F_W1: begin
        op        = OP_F_W1;
        state_nxt = ST_F_W2;
      end
      ST_F_W2: begin
        op        = OP_F_W2;
        state_nxt = ST_M_RD0;
      end
      ST_PUSH: begin
        if (out_free) begin
          op        = OP_PUSH;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == OP_PUSH) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      from_free_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_free_r <= from_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BTNF_ASSERT(a_accept_dispatch, (in_valid && in_ready) |=> (state_r == ST_DISPATCH), "accepted transaction not dispatched")
  `BTNF_ASSERT(a_rose_from_push, $rose(out_valid_r) |-> $past(state_r == ST_PUSH), "result raised outside push")
  `BTNF_ASSERT(a_push_lands, (state_r == ST_PUSH && out_free) |=> (out_valid_r && state_r == ST_IDLE), "push did not load output")
endmodule

// File: src/btnf_dp.sv
// ----------------------------------------------------------------------------
// btnf_dp
// tag memory, address arithmetic and working registers of the allocator
// ----------------------------------------------------------------------------
`include "boundary_tag_next_fit_allocator_unit_macros.svh"

module btnf_dp import btnf_pkg::*; #(
  parameter int unsigned HEAP_BYTES = DEF_HEAP_BYTES,
  parameter int unsigned GROW_BYTES = DEF_GROW_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  btnf_op_t           op,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [REQ_W-1:0]   in_request_bytes,
  input  logic [BADDR_W-1:0] in_block_address,
  output logic [PADDR_W-1:0] out_payload_address,
  output logic               out_success,
  output btnf_status_t       st
);
  localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
  localparam int IDX_W = $clog2(HEAP_WORDS);
  localparam logic [WORD_W-3:0] WORDS_LIM = (WORD_W-2)'(HEAP_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HEAP_WORDS - 1);
  localparam logic [WORD_W-1:0] GROW_W = WORD_W'(GROW_BYTES);
  localparam logic [WORD_W:0] HEAP_LIM = (WORD_W+1)'(HEAP_BYTES);

  logic [KIND_W-1:0]  kind_r;
  logic [REQ_W-1:0]   req_r;
  logic [BADDR_W-1:0] addr_r;
  logic [WORD_W-1:0]  asize_r, bp_r, rover_r, brk_r, gsize_r;
  logic [WORD_W-1:0]  prv_r, osz_r, nxt_r, nsz_r, acc_r, csize_r, rem_r, h_r, fsz_r;
  logic               prev_free_r, next_free_r, ok_r, oob_r;
  logic [PADDR_W-1:0] pay_r, out_pay_r;
  logic               out_ok_r;
  logic [IDX_W-1:0]   cnt_r;

  logic [WORD_W-1:0]  ram_q, rd_q, hd_sz, nxt_sum, addr32;
  logic [REQ_W:0]     req_sum;
  logic [WORD_W-1:0]  asize_c, ext_c, gs_c;
  logic [WORD_W-2:0]  wsum;
  logic               rd_en, wr_en, wr_in;
  logic [WORD_W-1:0]  rd_a, wr_a, wr_d;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_wa;
  logic [WORD_W-1:0]  ram_wd;

  // read data of words beyond the memory is zero
  assign rd_q    = oob_r ? '0 : ram_q;
  assign hd_sz   = {rd_q[WORD_W-1:3], 3'b000};
  assign nxt_sum = bp_r + hd_sz;
  assign addr32  = {{(WORD_W-BADDR_W){1'b0}}, addr_r};

  // request rounding and growth size
  assign req_sum = {1'b0, in_request_bytes} + (REQ_W+1)'(15);
  assign asize_c = (in_request_bytes <= REQ_W'(8)) ? MIN_BLOCK
                 : {{(WORD_W-REQ_W-1){1'b0}}, req_sum[REQ_W:3], 3'b000};
  assign ext_c   = (asize_r > GROW_W) ? asize_r : GROW_W;
  assign wsum    = {1'b0, ext_c[WORD_W-1:2]} + {{(WORD_W-2){1'b0}}, ext_c[2]};
  assign gs_c    = {wsum[WORD_W-3:0], 2'b00};

  always_comb begin
    st.sweep_last  = (cnt_r == LAST_IDX);
    st.kind_free   = (kind_r == KIND_FREE);
    st.req_zero    = (req_r == '0);
    st.s1_go       = (bp_r < brk_r);
    st.s2_go       = (bp_r < rover_r) && (bp_r < brk_r);
    st.sz_zero     = (hd_sz == '0);
    st.fits        = (hd_sz >= asize_r) && !rd_q[0];
    st.nxt_le      = (nxt_sum <= bp_r);
    st.grow_ok     = ({1'b0, bp_r} + {1'b0, gsize_r}) <= HEAP_LIM;
    st.prev_free   = prev_free_r;
    st.next_free   = !rd_q[0];
    st.split       = (hd_sz >= asize_r) && ((hd_sz - asize_r) >= MIN_BLOCK);
    st.free_pre_ok = (addr_r[2:0] == 3'b000) && (addr_r >= BADDR_W'(16))
                   && (addr32 < brk_r) && rd_q[0] && (hd_sz >= MIN_BLOCK)
                   && (({1'b0, addr32} + {1'b0, hd_sz}) <= {1'b0, brk_r});
    st.foot_eq     = (rd_q == h_r);
  end

  // memory port selection per command
  always_comb begin
    rd_en = 1'b0;
    rd_a  = bp_r - WORD_W'(4);
    wr_en = 1'b0;
    wr_a  = bp_r - WORD_W'(4);
    wr_d  = '0;
    case (op)
      OP_S_RD, OP_P_RD: rd_en = 1'b1;
      OP_M_RD0: begin
        rd_en = 1'b1;
        rd_a  = bp_r - WORD_W'(8);
      end
      OP_M_RD1: rd_en = 1'b1;
      OP_M_RD2: begin
        rd_en = 1'b1;
        rd_a  = nxt_sum - WORD_W'(4);
      end
      OP_M_RDP: begin
        rd_en = 1'b1;
        rd_a  = prv_r - WORD_W'(4);
      end
      OP_F_RD: begin
        rd_en = 1'b1;
        rd_a  = addr32 - WORD_W'(4);
      end
      OP_F_EVAL: begin
        rd_en = 1'b1;
        rd_a  = addr32 + hd_sz - WORD_W'(8);
      end
      OP_G_W1: begin
        wr_en = 1'b1;
        wr_d  = gsize_r;
      end
      OP_G_W2: begin
        wr_en = 1'b1;
        wr_a  = bp_r + gsize_r - WORD_W'(8);
        wr_d  = gsize_r;
      end
      OP_G_W3: begin
        wr_en = 1'b1;
        wr_a  = bp_r + gsize_r - WORD_W'(4);
        wr_d  = EPI_TAG;
      end
      OP_M_WA: begin
        wr_en = 1'b1;
        wr_d  = acc_r;
        if (!prev_free_r) wr_a = bp_r - WORD_W'(4);
        else if (!next_free_r) wr_a = bp_r + osz_r - WORD_W'(8);
        else wr_a = prv_r - WORD_W'(4);
      end
      OP_M_WB: begin
        wr_en = 1'b1;
        wr_d  = acc_r;
        if (!prev_free_r) wr_a = bp_r + acc_r - WORD_W'(8);
        else if (!next_free_r) wr_a = prv_r - WORD_W'(4);
        else wr_a = nxt_r + nsz_r - WORD_W'(8);
      end
      OP_P_W1: begin
        wr_en = 1'b1;
        wr_d  = asize_r | WORD_W'(1);
      end
      OP_P_W2: begin
        wr_en = 1'b1;
        wr_a  = bp_r + asize_r - WORD_W'(8);
        wr_d  = asize_r | WORD_W'(1);
      end
      OP_P_W3: begin
        wr_en = 1'b1;
        wr_a  = bp_r + asize_r - WORD_W'(4);
        wr_d  = rem_r;
      end
      OP_P_W4: begin
        wr_en = 1'b1;
        wr_a  = bp_r + csize_r - WORD_W'(8);
        wr_d  = rem_r;
      end
      OP_P_N1: begin
        wr_en = 1'b1;
        wr_d  = csize_r | WORD_W'(1);
      end
      OP_P_N2: begin
        wr_en = 1'b1;
        wr_a  = bp_r + csize_r - WORD_W'(8);
        wr_d  = csize_r | WORD_W'(1);
      end
      OP_F_W1: begin
        wr_en = 1'b1;
        wr_a  = addr32 - WORD_W'(4);
        wr_d  = fsz_r;
      end
      OP_F_W2: begin
        wr_en = 1'b1;
        wr_a  = addr32 + fsz_r - WORD_W'(8);
        wr_d  = fsz_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // writes beyond the memory are dropped, the clearing pass writes the reset image
  assign wr_in  = (wr_a[WORD_W-1:2] < WORDS_LIM);
  assign ram_we = (op == OP_CLEAR) || (wr_en && wr_in);
  assign ram_wa = (op == OP_CLEAR) ? cnt_r : wr_a[IDX_W+1:2];
  assign ram_wd = (op == OP_CLEAR) ? init_word(WORD_W'(cnt_r)) : wr_d;

  btnf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (HEAP_WORDS)
  ) u_tag_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (rd_en),
    .raddr (rd_a[IDX_W+1:2]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rd_en) oob_r <= !(rd_a[WORD_W-1:2] < WORDS_LIM);
    case (op)
      OP_LOAD: begin
        kind_r  <= in_kind;
        req_r   <= in_request_bytes;
        addr_r  <= in_block_address;
        asize_r <= asize_c;
        bp_r    <= rover_r;
        pay_r   <= '0;
        ok_r    <= 1'b0;
      end
      OP_S_EVAL: begin
        if (!st.fits) bp_r <= nxt_sum;
      end
      OP_S2_INIT: bp_r <= HEAP_START;
      OP_G_INIT: begin
        gsize_r <= gs_c;
        bp_r    <= brk_r;
      end
      OP_M_RD1: begin
        prev_free_r <= !rd_q[0];
        prv_r       <= bp_r - hd_sz;
      end
      OP_M_RD2: begin
        osz_r <= hd_sz;
        nxt_r <= nxt_sum;
      end
      OP_M_EVAL: begin
        next_free_r <= !rd_q[0];
        nsz_r       <= hd_sz;
        acc_r       <= osz_r + (rd_q[0] ? '0 : hd_sz);
      end
      OP_M_ADDP: acc_r <= acc_r + hd_sz;
      OP_M_FIN: begin
        if (prev_free_r) bp_r <= prv_r;
      end
      OP_P_EVAL: begin
        csize_r <= hd_sz;
        rem_r   <= hd_sz - asize_r;
        pay_r   <= bp_r[PADDR_W-1:0];
        ok_r    <= 1'b1;
      end
      OP_F_EVAL: begin
        h_r   <= rd_q;
        fsz_r <= hd_sz;
      end
      OP_F_W1: bp_r <= addr32;
      OP_F_W2: ok_r <= 1'b1;
      OP_PUSH: begin
        out_pay_r <= pay_r;
        out_ok_r  <= ok_r;
      end
      default: begin
        ok_r <= ok_r;
      end
    endcase
  end

  // allocator control state: rover, break and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rover_r <= INIT_ROVER;
      brk_r   <= INIT_BREAK;
      cnt_r   <= '0;
    end else begin
      if (op == OP_CLEAR) cnt_r <= cnt_r + IDX_W'(1);
      if (op == OP_S_EVAL && st.fits) rover_r <= bp_r;
      if (op == OP_M_FIN) rover_r <= prev_free_r ? prv_r : bp_r;
      if (op == OP_G_W3) brk_r <= bp_r + gsize_r;
    end
  end

  assign out_payload_address = out_pay_r;
  assign out_success         = out_ok_r;

  `BTNF_ASSERT(a_break_bound, ({1'b0, brk_r} <= HEAP_LIM), "break past heap end")
endmodule

// File: src/boundary_tag_next_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// boundary_tag_next_fit_allocator_unit
// one transaction in flight at a time; out valid rises when its result is pushed
// allocate: next-fit search from the rover to the break, then from the heap start to the rover,
// heap growth with a merge when no block fits (growth may fail), a split when the remainder is
// at least MIN_BLOCK; size zero: no search; free: rejected by the checks, or accepted and merged
// the next request can be taken in the cycle after push; a full output register holds push
// after reset a clearing pass writes the initial layout to every tag word, in ready low
// ----------------------------------------------------------------------------
module boundary_tag_next_fit_allocator_unit import btnf_pkg::*; #(
  parameter int unsigned HEAP_BYTES = DEF_HEAP_BYTES,
  parameter int unsigned GROW_BYTES = DEF_GROW_BYTES
) (
  input logic         clk,
  input logic         rst_n,
  btnf_in_if.sink     in_ch,
  btnf_out_if.source  out_ch
);
  // command and status between sequencer and datapath
  btnf_op_t     op;
  btnf_status_t st;

  // sequencer: clearing pass, search walk, growth, merge, split, free checks;
  // the result sits in an output register so a new request can be taken
  // while the previous result waits
  btnf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .op        (op)
  );

  // datapath: tag memory with registered read, rover, break and work registers
  btnf_dp #(
    .HEAP_BYTES (HEAP_BYTES),
    .GROW_BYTES (GROW_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .in_kind             (in_ch.kind),
    .in_request_bytes    (in_ch.request_bytes),
    .in_block_address    (in_ch.block_address),
    .out_payload_address (out_ch.payload_address),
    .out_success         (out_ch.success),
    .st                  (st)
  );
endmodule

// File: tb/boundary_tag_next_fit_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// next-fit allocator testbench
// drives allocate and free transactions, predicts each result with a local
// model of the boundary-tag heap and checks every result in order
// ----------------------------------------------------------------------------
module boundary_tag_next_fit_allocator_unit_tb import btnf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_LIMIT = 65536;
  localparam int unsigned GROW_STEP  = 4096;
  localparam int unsigned TAG_WORDS  = HEAP_LIMIT / 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  btnf_in_if  in_ch ();
  btnf_out_if out_ch ();

  boundary_tag_next_fit_allocator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // one predicted result
  typedef struct packed {
    logic [PADDR_W-1:0] payload_address;
    logic               success;
  } alloc_result_t;

  // local copy of the heap state
  logic [31:0] tags [TAG_WORDS];
  logic [31:0] brk_ofs;
  logic [31:0] rov;
  logic [31:0] hstart;

  alloc_result_t pending_results [$];
  logic [15:0]   live_blocks [$];
  int  errors = 0;
  bit  allow_stall = 1'b1;

  // ---------------------------------------------------------------- heap model
  function automatic logic [31:0] tag_rd(input logic [31:0] a);
    return ((a >> 2) < TAG_WORDS) ? tags[a >> 2] : 32'd0;
  endfunction

  function automatic void tag_wr(input logic [31:0] a, input logic [31:0] v);
    if ((a >> 2) < TAG_WORDS) tags[a >> 2] = v;
  endfunction

  function automatic logic [31:0] blk_size(input logic [31:0] a);
    return tag_rd(a) & ~32'd7;
  endfunction

  function automatic logic [31:0] coalesce(input logic [31:0] bp);
    logic        pf, nf;
    logic [31:0] size, nxt, prv, nsz;
    pf   = ((tag_rd(bp - 8) & 32'd1) == 32'd0);
    size = blk_size(bp - 4);
    nxt  = bp + size;
    nf   = ((tag_rd(nxt - 4) & 32'd1) == 32'd0);
    prv  = bp - blk_size(bp - 8);
    if (!pf && !nf) return bp;
    if (!pf) begin
      size += blk_size(nxt - 4);
      tag_wr(bp - 4, size);
      tag_wr(bp + size - 8, size);
    end else if (!nf) begin
      size += blk_size(prv - 4);
      tag_wr(bp + blk_size(bp - 4) - 8, size);
      tag_wr(prv - 4, size);
      bp = prv;
    end else begin
      nsz = blk_size(nxt - 4);
      size += blk_size(prv - 4) + nsz;
      tag_wr(prv - 4, size);
      tag_wr(nxt + nsz - 8, size);
      bp = prv;
    end
    rov = bp;
    return bp;
  endfunction

  function automatic logic [31:0] heap_grow(input logic [31:0] bytes);
    logic [31:0] words, size, bp;
    words = bytes >> 2;
    size  = (words[0] ? words + 1 : words) * 4;
    bp    = brk_ofs;
    if (64'(bp) + 64'(size) > 64'(HEAP_LIMIT)) return 32'd0;
    tag_wr(bp - 4, size);
    tag_wr(bp + size - 8, size);
    tag_wr(bp + size - 4, 32'd1);
    brk_ofs = bp + size;
    return coalesce(bp);
  endfunction

  function automatic bit block_fits(input logic [31:0] bp, input logic [31:0] asize);
    return blk_size(bp - 4) >= asize && ((tag_rd(bp - 4) & 32'd1) == 32'd0);
  endfunction

  function automatic logic [31:0] rover_search(input logic [31:0] asize);
    logic [31:0] bp, nxt;
    bp = rov;
    while (bp < brk_ofs && blk_size(bp - 4) != 0) begin
      if (block_fits(bp, asize)) begin
        rov = bp;
        return bp;
      end
      nxt = bp + blk_size(bp - 4);
      if (nxt <= bp) break;
      bp = nxt;
    end
    bp = hstart;
    while (bp < rov && bp < brk_ofs) begin
      if (block_fits(bp, asize)) begin
        rov = bp;
        return bp;
      end
      nxt = bp + blk_size(bp - 4);
      if (nxt <= bp) break;
      bp = nxt;
    end
    return 32'd0;
  endfunction

  function automatic void carve(input logic [31:0] bp, input logic [31:0] asize);
    logic [31:0] csize;
    csize = blk_size(bp - 4);
    if (csize >= asize && csize - asize >= 16) begin
      tag_wr(bp - 4, asize | 1);
      tag_wr(bp + asize - 8, asize | 1);
      bp += asize;
      tag_wr(bp - 4, csize - asize);
      tag_wr(bp + (csize - asize) - 8, csize - asize);
    end else begin
      tag_wr(bp - 4, csize | 1);
      tag_wr(bp + csize - 8, csize | 1);
    end
  endfunction

  function automatic void heap_reset();
    foreach (tags[i]) tags[i] = '0;
    tag_wr(4, 32'd9);
    tag_wr(8, 32'd9);
    tag_wr(12, 32'd1);
    hstart  = 32'd8;
    brk_ofs = 32'd16;
    rov     = 32'd0;
    void'(heap_grow(32'd4));
    void'(heap_grow(32'd4096));
  endfunction

  function automatic alloc_result_t heap_apply(input logic [KIND_W-1:0] kind,
                                               input logic [REQ_W-1:0] req,
                                               input logic [BADDR_W-1:0] baddr);
    alloc_result_t r;
    logic [31:0] asize, bp, h, size, addr;
    r = '0;
    if (kind == KIND_ALLOC) begin
      if (req != 0) begin
        asize = (req <= 8) ? 32'd16 : 8 * ((32'(req) + 15) / 8);
        bp = rover_search(asize);
        if (bp == 0) bp = heap_grow(asize > GROW_STEP ? asize : GROW_STEP);
        if (bp != 0) begin
          carve(bp, asize);
          r.payload_address = bp[15:0];
          r.success = 1'b1;
        end
      end
    end else begin
      addr = 32'(baddr);
      h    = tag_rd(addr - 4);
      size = h & ~32'd7;
      if (addr[2:0] == 0 && addr >= 16 && addr < brk_ofs && h[0] && size >= 16 &&
          64'(addr) + 64'(size) <= 64'(brk_ofs) && tag_rd(addr + size - 8) == h) begin
        tag_wr(addr - 4, size);
        tag_wr(addr + size - 8, size);
        void'(coalesce(addr));
        r.success = 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [REQ_W-1:0] req,
                              input logic [BADDR_W-1:0] baddr);
    alloc_result_t r;
    if (allow_stall && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.request_bytes <= req;
    in_ch.block_address <= baddr;
    do @(posedge clk); while (!in_ch.ready);
    r = heap_apply(kind, req, baddr);
    pending_results.push_back(r);
    // remember live blocks so frees mostly hit real ones
    if (kind == KIND_ALLOC && r.success) live_blocks.push_back(r.payload_address);
    in_ch.valid <= 1'b0;
    // the unit is busy right after an accept, so nothing is lost here
    @(posedge clk);
  endtask

  task automatic alloc_req(input logic [REQ_W-1:0] req);
    send_request(KIND_ALLOC, req, BADDR_W'($urandom));
  endtask

  task automatic free_req(input logic [BADDR_W-1:0] baddr);
    send_request(KIND_FREE, REQ_W'($urandom), baddr);
  endtask

  task automatic free_live_random();
    int k;
    logic [15:0] a;
    k = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[k];
    live_blocks.delete(k);
    free_req(a);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result sink, with random back-pressure while allow_stall is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected transaction: payload_address %0d success %0d",
                 out_ch.payload_address, out_ch.success);
          errors++;
        end else begin
          alloc_result_t e;
          e = pending_results.pop_front();
          if (out_ch.payload_address !== e.payload_address) begin
            $error("payload_address: expected %0d actual %0d",
                   e.payload_address, out_ch.payload_address);
            errors++;
          end
          if (out_ch.success !== e.success) begin
            $error("success: expected %0d actual %0d", e.success, out_ch.success);
            errors++;
          end
        end
      end
      out_ch.ready <= allow_stall ? ($urandom_range(0, 4) != 0) : 1'b1;
    end
  end

  // ---------------------------------------------------------------- tests
  // sizes at the edges of rounding, zero size, requests larger than the heap
  task automatic test_alloc_sizes();
    alloc_req(17'd0);
    alloc_req(17'd1);
    alloc_req(17'd8);
    alloc_req(17'd9);
    alloc_req(17'd16);
    alloc_req(17'd4088);
    alloc_req(17'd65536);
    alloc_req(17'h1FFFF & 17'd100000);
  endtask

  // merges with neither or both neighbors free, plus bad and double frees
  task automatic test_free_cases();
    logic [15:0] a, b, c, d;
    a = 0;
    alloc_req(17'd24); a = pending_results[$].payload_address;
    alloc_req(17'd24); b = pending_results[$].payload_address;
    alloc_req(17'd24); c = pending_results[$].payload_address;
    alloc_req(17'd24); d = pending_results[$].payload_address;
    free_req(a);        // neither neighbor free
    free_req(c);        // isolated
    free_req(b);        // both neighbors free
    free_req(b);        // double free
    free_req(d);        // prev and next free
    free_req(16'd0);
    free_req(16'd12);
    free_req(16'hFFFF);
    free_req(16'hFFF8);
    live_blocks.delete();
  endtask

  // fill the heap until growth fails, then release every block it allocated
  task automatic test_heap_full();
    repeat (20) alloc_req(17'd8000);
    wait_drained();   // sender holds until all results are back
    while (live_blocks.size() != 0) free_live_random();
  endtask

  task automatic test_random_mix(input int n);
    repeat (n) begin
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        if ($urandom_range(0, 9) == 0) alloc_req(REQ_W'($urandom_range(0, 65536)));
        else alloc_req(REQ_W'($urandom_range(1, 600)));
      end else if (sel < 85 && live_blocks.size() != 0) begin
        free_live_random();
      end else if (sel < 92) begin
        free_req(BADDR_W'($urandom));
      end else begin
        alloc_req(REQ_W'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_ALLOC;
    in_ch.request_bytes <= '0;
    in_ch.block_address <= '0;
    heap_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_alloc_sizes();
    test_free_cases();
    test_heap_full();
    test_random_mix(450);
    allow_stall = 1'b0;   // last stretch runs without idling
    test_random_mix(120);
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog: clearing pass plus slow searches with stalls, several times over
  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/btnf_pkg.sv
src/btnf_in_if.sv
src/btnf_out_if.sv
src/btnf_ram.sv
src/btnf_ctrl.sv
src/btnf_dp.sv
src/boundary_tag_next_fit_allocator_unit.sv
tb/boundary_tag_next_fit_allocator_unit_tb.sv
